@@ hw/rtl/kpq_pkg.sv @@
// Shared types, constants and key helpers for the keyed priority queue table.
package kpq_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int KEY_CHARS    = 16;
    localparam int KEY_MAX      = 16;
    localparam int KEY_W        = 8 * KEY_MAX;
    localparam int PRIO_W       = 8;
    localparam int SLOT_W       = 5;
    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 6;
    localparam int IN_DATA_W    = 144;
    localparam int OUT_DATA_W   = 144;
    localparam int OUT_USED_W   = 1 + COUNT_W + KEY_W + PRIO_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY,
        ST_REMOVE,
        ST_SORT,
        ST_ROTATE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_APPLY,
        CELL_REMOVE,
        CELL_SORT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic                phase;
        logic                found;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    key_fold;
        logic [PRIO_W-1:0]   prio;
        logic [SLOT_W-1:0]   slot;
    } cell_ctrl_t;

    // Cut the key at its first zero character or after KEY_CHARS characters.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (k[KEY_W-1-8*i -: 8] == 8'h00 || i >= KEY_CHARS)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
            end
        end
        return r;
    endfunction

    // Fold A..Z to a..z in every character.
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       c;
        r = k;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            c = k[8*i +: 8];
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                r[8*i +: 8] = c + 8'h20;
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/kpq_cell.sv @@
// One table entry: key and priority storage with its local match, shift and swap logic.
module kpq_cell
    import kpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX      = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cell_ctrl_t                        ctrl,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    input  logic [KEY_W-1:0]                  prev_key,
    input  logic [PRIO_W-1:0]                 prev_prio,
    input  logic [KEY_W-1:0]                  next_key,
    input  logic [PRIO_W-1:0]                 next_prio,
    output logic [KEY_W-1:0]                  key,
    output logic [PRIO_W-1:0]                 prio,
    output logic                              match
);

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic              match_reg;
    logic              match_next;
    logic              valid;
    logic              lower_side;
    logic              swap_lo;
    logic              swap_hi;

    always_comb
    begin
        valid      = IDX < int'(count);
        lower_side = ((IDX % 2) == int'(ctrl.phase));
        // Swap only strictly inverted pairs so equal priorities keep their order.
        swap_lo    = lower_side && ((IDX + 1) < int'(count)) && (prio_reg < next_prio);
        swap_hi    = !lower_side && (IDX != 0) && valid && (prev_prio < prio_reg);
    end

    always_comb
    begin
        key_next   = key_reg;
        prio_next  = prio_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_MATCH:
            begin
                match_next = valid && (fold_key(key_reg) == ctrl.key_fold);
            end
            CELL_APPLY:
            begin
                if (ctrl.found)
                begin
                    if (match_reg)
                    begin
                        prio_next = ctrl.prio;
                    end
                end
                else if (IDX == int'(count))
                begin
                    key_next  = ctrl.key;
                    prio_next = ctrl.prio;
                end
            end
            CELL_REMOVE:
            begin
                if (IDX >= int'(ctrl.slot))
                begin
                    key_next  = next_key;
                    prio_next = next_prio;
                end
            end
            CELL_SORT:
            begin
                if (swap_lo)
                begin
                    key_next  = next_key;
                    prio_next = next_prio;
                end
                else if (swap_hi)
                begin
                    key_next  = prev_key;
                    prio_next = prev_prio;
                end
            end
            CELL_ROTATE:
            begin
                key_next  = next_key;
                prio_next = next_prio;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign prio  = prio_reg;
    assign match = match_reg;

endmodule

@@ hw/rtl/kpq_ctrl.sv @@
// Command sequencer: stream handshakes, entry count, cell commands and the result register.
module kpq_ctrl
    import kpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_DATA_W-1:0]              s_tdata,
    input  logic [MODE_W-1:0]                 s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_DATA_W-1:0]             m_tdata,
    input  logic [CAPACITY-1:0]               match_vec,
    input  logic [KEY_W-1:0]                  head_key,
    input  logic [PRIO_W-1:0]                 head_prio,
    output cell_ctrl_t                        cell_ctrl,
    output logic [$clog2(CAPACITY+1)-1:0]     count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(CAPACITY);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [RW-1:0]          rounds_reg;
    logic [RW-1:0]          rounds_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       key_next;
    logic [KEY_W-1:0]       fold_reg;
    logic [KEY_W-1:0]       fold_next;
    logic [PRIO_W-1:0]      prio_reg;
    logic [PRIO_W-1:0]      prio_next;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic                   ok_reg;
    logic                   ok_next;
    logic [KEY_W-1:0]       rd_key_reg;
    logic [KEY_W-1:0]       rd_key_next;
    logic [PRIO_W-1:0]      rd_prio_reg;
    logic [PRIO_W-1:0]      rd_prio_next;

    logic                   accept;
    logic                   load_out;
    logic                   found;
    logic                   last_round;
    mode_t                  mode_in;
    logic [KEY_W-1:0]       key_in_norm;
    logic [SLOT_W-1:0]      slot_in;
    logic                   slot_in_range;
    logic                   table_full;

    always_comb
    begin
        mode_in       = mode_t'(s_tuser);
        key_in_norm   = normalize_key({s_tdata[63:0], s_tdata[127:64]});
        slot_in       = s_tdata[140:136];
        slot_in_range = int'(slot_in) < int'(count_reg);
        table_full    = (count_reg == CW'(CAPACITY));
        found         = |match_vec;
        last_round    = (rounds_reg == RW'(CAPACITY - 1));
        accept        = s_tvalid && s_tready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_in)
                        MODE_ADD:    state_next = table_full ? ST_DONE : ST_MATCH;
                        MODE_REMOVE: state_next = slot_in_range ? ST_REMOVE : ST_DONE;
                        MODE_CLEAR:  state_next = ST_DONE;
                        MODE_READ:   state_next = slot_in_range ? ST_ROTATE : ST_DONE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_MATCH:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_SORT;
            ST_REMOVE: state_next = ST_DONE;
            ST_SORT:   state_next = last_round ? ST_DONE : ST_SORT;
            ST_ROTATE: state_next = last_round ? ST_DONE : ST_ROTATE;
            ST_DONE:   state_next = load_out ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        s_tready           = (state_reg == ST_IDLE);
        load_out           = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
        cell_ctrl.phase    = rounds_reg[0];
        cell_ctrl.found    = found;
        cell_ctrl.key      = key_reg;
        cell_ctrl.key_fold = fold_reg;
        cell_ctrl.prio     = prio_reg;
        cell_ctrl.slot     = slot_reg;
        unique case (state_reg)
            ST_MATCH:  cell_ctrl.op = CELL_MATCH;
            ST_APPLY:  cell_ctrl.op = CELL_APPLY;
            ST_REMOVE: cell_ctrl.op = CELL_REMOVE;
            ST_SORT:   cell_ctrl.op = CELL_SORT;
            ST_ROTATE: cell_ctrl.op = CELL_ROTATE;
            default:   cell_ctrl.op = CELL_HOLD;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        count_next     = count_reg;
        rounds_next    = rounds_reg;
        key_next       = key_reg;
        fold_next      = fold_reg;
        prio_next      = prio_reg;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        rd_key_next    = rd_key_reg;
        rd_prio_next   = rd_prio_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (accept)
        begin
            key_next     = key_in_norm;
            fold_next    = fold_key(key_in_norm);
            prio_next    = s_tdata[135:128];
            slot_next    = slot_in;
            rd_key_next  = '0;
            rd_prio_next = '0;
            rounds_next  = '0;
            unique case (mode_in)
                MODE_ADD:    ok_next = !table_full;
                MODE_REMOVE: ok_next = slot_in_range;
                MODE_CLEAR:
                begin
                    ok_next    = (count_reg != '0);
                    count_next = '0;
                end
                MODE_READ:   ok_next = slot_in_range;
                default:     ok_next = 1'b0;
            endcase
        end

        unique case (state_reg)
            ST_APPLY:
            begin
                if (!found)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_REMOVE:
            begin
                count_next = count_reg - CW'(1);
            end
            ST_SORT:
            begin
                rounds_next = rounds_reg + RW'(1);
            end
            ST_ROTATE:
            begin
                rounds_next = rounds_reg + RW'(1);
                // The head holds entry k after k rotation steps.
                if (int'(rounds_reg) == int'(slot_reg))
                begin
                    rd_key_next  = head_key;
                    rd_prio_next = head_prio;
                end
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, rd_prio_reg,
                              rd_key_reg[63:0], rd_key_reg[KEY_W-1:64],
                              COUNT_W'(count_reg), ok_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rounds_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rounds_reg    <= rounds_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        fold_reg     <= fold_next;
        prio_reg     <= prio_next;
        slot_reg     <= slot_next;
        ok_reg       <= ok_next;
        rd_key_reg   <= rd_key_next;
        rd_prio_reg  <= rd_prio_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign count    = count_reg;

endmodule

@@ hw/rtl/keyed_priority_queue_table_top.sv @@
// Keyed priority queue table: sequencer plus a ring of entry cells.
//
// Usage:
//   Commands enter on the s_ stream (tuser = mode: add/update, remove, clear, read).
//   Every command transaction yields exactly one result transaction on m_ with the
//   status, the entry count after the command and, for a read, the entry read.
//   Entries live in a ring of CAPACITY cells kept in descending priority order.
//   Steps from input transaction to result:
//     add/update : match, apply, CAPACITY odd-even sort rounds
//     read       : one full rotation of the ring past the head cell
//     remove     : every cell behind the slot shifts up at once
//     clear, or any failed command : no cell step
//   One command is worked at a time; s_tready rises in the same cycle as the result
//   is registered, so each command waits for the one before it. The sort rounds
//   and the ring rotation across the chain of cells take the most time.
//   Reset empties the table (count zero) and drops any pending result.
//   A stalled receiver holds the result in the output register; the next command is
//   still accepted and runs up to its own result, which then waits for the slot.
module keyed_priority_queue_table_top
    import kpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [63:0] key_high, [127:64] key_low, [135:128] priority_req, [140:136] slot
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [6:1] count, [70:7] entry_key_high, [134:71] entry_key_low,
    // [142:135] entry_priority
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);

    cell_ctrl_t          cell_ctrl;
    logic [CW-1:0]       cell_count;
    logic [CAPACITY-1:0] match_vec;
    logic [KEY_W-1:0]    key_arr  [CAPACITY];
    logic [PRIO_W-1:0]   prio_arr [CAPACITY];

    kpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .match_vec (match_vec),
        .head_key  (key_arr[0]),
        .head_prio (prio_arr[0]),
        .cell_ctrl (cell_ctrl),
        .count     (cell_count)
    );

    // Ring of cells: each cell sees its neighbors; the tail wraps to the head so the
    // whole table can rotate past cell 0 for reads.
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        localparam int PREV = (j == 0) ? CAPACITY - 1 : j - 1;
        localparam int NEXT = (j == CAPACITY - 1) ? 0 : j + 1;

        kpq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .count     (cell_count),
            .prev_key  (key_arr[PREV]),
            .prev_prio (prio_arr[PREV]),
            .next_key  (key_arr[NEXT]),
            .next_prio (prio_arr[NEXT]),
            .key       (key_arr[j]),
            .prio      (prio_arr[j]),
            .match     (match_vec[j])
        );
    end

    // Table never holds more than CAPACITY entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cell_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Keys are unique under case folding, so at most one cell matches.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // Commands are taken only while the cells are idle.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (cell_ctrl.op == CELL_HOLD))
        else $error("command accepted while the cells are busy");

    // A clear empties the table at once.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_CLEAR)) |=> (cell_count == '0))
        else $error("clear left entries in the table");

endmodule
